[rtl/sampler_sequencer_mixer_unit_assert.svh]
// Assertion macros for the sampler sequencer mixer unit.
`ifndef SAMPLER_SEQUENCER_MIXER_UNIT_ASSERT_SVH
`define SAMPLER_SEQUENCER_MIXER_UNIT_ASSERT_SVH
`define SSM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/ssm_pkg.sv]
// ---------------------------------------------------------------------------
// ssm_pkg
// Shared constants and types of the sampler sequencer mixer unit.
// ---------------------------------------------------------------------------
package ssm_pkg;
  localparam int NumVoicesDef   = 8;
  localparam int NumStepsDef    = 16;
  localparam int NumSoundsDef   = 4;
  localparam int SampleDepthDef = 4096;
  localparam logic [7:0]  MidLevel      = 8'd128;
  localparam logic [19:0] DebounceReset = 20'd70000;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_STEP  = 2'd1,
    REQ_PRESS = 2'd2,
    REQ_AUDIO = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    CFG_LEN0 = 3'd0,
    CFG_LEN1 = 3'd1,
    CFG_LEN2 = 3'd2,
    CFG_LEN3 = 3'd3,
    CFG_DEB  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MIXRD,
    ST_MIXACC,
    ST_DONE
  } state_t;
endpackage

[rtl/ssm_ram.sv]
// ---------------------------------------------------------------------------
// ssm_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module ssm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/sampler_sequencer_mixer_unit.sv]
// ---------------------------------------------------------------------------
// sampler_sequencer_mixer_unit
// Drum sampler: sample store in RAM, step grid, voice allocation, mixer.
// ---------------------------------------------------------------------------
// channel | handshake           | content
// in      | in_valid/in_ready   | req_type sample_id byte_addr byte_value time_us
// out     | out_valid/out_ready | audio_out seq_step step_column voices_busy accepted
// cfg     | cfg_valid/cfg_ready | cfg_index cfg_data
// Load and press: ST_START, then ST_DONE. Step tick: ST_START walks the sounds.
// Audio tick: ST_MIXRD then ST_MIXACC per voice, one sample-RAM read per voice.
// Reset is synchronous; the sample RAM has no reset.
// A stalled output holds the block; the next request enters once it is taken.
module sampler_sequencer_mixer_unit
  import ssm_pkg::*;
#(
  parameter int NUM_VOICES   = NumVoicesDef,
  parameter int STEP_COUNT   = NumStepsDef,
  parameter int NUM_SOUNDS   = NumSoundsDef,
  parameter int SAMPLE_DEPTH = SampleDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [1:0]  sample_id,
  input  logic [11:0] byte_addr,
  input  logic [7:0]  byte_value,
  input  logic [47:0] time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  audio_out,
  output logic [3:0]  seq_step,
  output logic [3:0]  step_column,
  output logic [7:0]  voices_busy,
  output logic        accepted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int SW = (NUM_SOUNDS > 1) ? $clog2(NUM_SOUNDS) : 1;
  localparam int TW = $clog2(STEP_COUNT);
  localparam int AW = $clog2(SAMPLE_DEPTH);
  localparam int PW = AW + 1;
  localparam int MW = SW + AW;
  localparam int IW = ((VW > SW) ? VW : SW) + 1;

  state_t state, state_next;

  logic [12:0] slen [NUM_SOUNDS];
  logic [19:0] debounce;
  logic [STEP_COUNT-1:0] grid [NUM_SOUNDS];
  logic [TW-1:0] step;
  logic [NUM_VOICES-1:0] vact;
  logic [SW-1:0] vsmp [NUM_VOICES];
  logic [PW-1:0] vpos [NUM_VOICES];
  logic [47:0] lastp [NUM_SOUNDS];
  logic [NUM_SOUNDS-1:0] seen;

  logic [1:0]  r_type;
  logic [1:0]  r_sid;
  logic [47:0] r_time;
  logic [IW-1:0] idx;
  logic [8:0]  acc;
  logic        flag;

  logic          ram_we;
  logic [MW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  function automatic logic [PW-1:0] eff_len(input logic [12:0] n);
    logic [PW-1:0] r;
    if (32'(n) > SAMPLE_DEPTH) begin
      r = PW'(SAMPLE_DEPTH);
    end else begin
      r = PW'(n);
    end
    return r;
  endfunction

  logic [NUM_VOICES-1:0] playing;
  always_comb begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      playing[v] = vact[v] && (vpos[v] < eff_len(slen[vsmp[v]]));
    end
  end

  // first idle voice
  logic          free_found;
  logic [VW-1:0] free_v;
  always_comb begin
    free_found = 1'b0;
    free_v = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (!playing[v]) begin
        free_found = 1'b1;
        free_v = VW'(v);
      end
    end
  end

  logic          in_sid_ok;
  logic [SW-1:0] sid_s;
  logic [47:0]   diff;
  logic          press_ok;
  assign in_sid_ok = 32'(r_sid) < NUM_SOUNDS;
  assign sid_s = SW'(r_sid);
  assign diff = r_time - lastp[sid_s];
  assign press_ok = in_sid_ok && (!seen[sid_s] || diff > 48'(debounce));

  logic [VW-1:0] vi;
  logic [SW-1:0] si;
  assign vi = VW'(idx);
  assign si = SW'(idx);

  logic [TW-1:0] step_inc;
  assign step_inc = (32'(step) == STEP_COUNT - 1) ? '0 : step + 1'b1;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !in_valid;
  assign out_valid = (state == ST_DONE);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        unique case (req_t'(r_type))
          REQ_STEP:  state_next = (32'(idx) == NUM_SOUNDS - 1) ? ST_DONE : ST_START;
          REQ_AUDIO: state_next = ST_MIXRD;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_MIXRD:  state_next = ST_MIXACC;
      ST_MIXACC: state_next = (32'(idx) == NUM_VOICES - 1) ? ST_DONE : ST_MIXRD;
      ST_DONE: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = {vsmp[vi], vpos[vi][AW-1:0]};
    if (state == ST_IDLE && in_valid && req_t'(req_type) == REQ_LOAD
        && 32'(sample_id) < NUM_SOUNDS) begin
      ram_we = 1'b1;
      ram_addr = {SW'(sample_id), AW'(byte_addr)};
    end
  end

  ssm_ram #(.Width(8), .Depth(1 << MW)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(byte_value),
    .rdata(ram_rdata)
  );

  logic [9:0] sum;
  assign sum = 10'(acc) + 10'(ram_rdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int s = 0; s < NUM_SOUNDS; s++) begin
        slen[s] <= '0;
        grid[s] <= '0;
        lastp[s] <= '0;
      end
      seen <= '0;
      debounce <= DebounceReset;
      step <= '0;
      vact <= '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        vsmp[v] <= '0;
        vpos[v] <= '0;
      end
      idx <= '0;
      acc <= 9'(MidLevel);
      flag <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEB) begin
          debounce <= cfg_data;
        end else if (32'(cfg_index) < NUM_SOUNDS) begin
          slen[SW'(cfg_index)] <= cfg_data[12:0];
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            r_type <= req_type;
            r_sid  <= sample_id;
            r_time <= time_us;
            idx    <= '0;
            acc    <= 9'(MidLevel);
            flag   <= 1'b0;
            if (req_t'(req_type) == REQ_STEP) begin
              step <= step_inc;
            end
          end
        end
        ST_START: begin
          unique case (req_t'(r_type))
            REQ_STEP: begin
              idx <= idx + 1'b1;
              if (grid[si][step] && slen[si] != '0 && free_found) begin
                vact[free_v] <= 1'b1;
                vsmp[free_v] <= si;
                vpos[free_v] <= '0;
                flag <= 1'b1;
              end
            end
            REQ_PRESS: begin
              if (press_ok) begin
                lastp[sid_s] <= r_time;
                seen[sid_s] <= 1'b1;
                grid[sid_s][step] <= ~grid[sid_s][step];
                flag <= 1'b1;
                if (slen[sid_s] != '0 && free_found) begin
                  vact[free_v] <= 1'b1;
                  vsmp[free_v] <= sid_s;
                  vpos[free_v] <= '0;
                end
              end
            end
            default: ;
          endcase
        end
        ST_MIXRD: ;
        ST_MIXACC: begin
          idx <= idx + 1'b1;
          if (vact[vi]) begin
            if (!playing[vi]) begin
              vact[vi] <= 1'b0;
            end else begin
              if (sum < 10'(MidLevel)) begin
                acc <= '0;
              end else if (sum - 10'(MidLevel) > 10'd255) begin
                acc <= 9'd255;
              end else begin
                acc <= 9'(sum - 10'(MidLevel));
              end
              vpos[vi] <= vpos[vi] + 1'b1;
              if (vpos[vi] + 1'b1 >= eff_len(slen[vsmp[vi]])) begin
                vact[vi] <= 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    audio_out = (req_t'(r_type) == REQ_AUDIO) ? acc[7:0] : MidLevel;
    seq_step = 4'(step);
    step_column = '0;
    for (int s = 0; s < NUM_SOUNDS && s < 4; s++) begin
      step_column[s] = grid[s][step];
    end
    voices_busy = '0;
    for (int v = 0; v < NUM_VOICES && v < 8; v++) begin
      voices_busy[v] = playing[v];
    end
    accepted = flag;
  end
endmodule

[rtl/ssm_checker.sv]
// ---------------------------------------------------------------------------
// ssm_checker
// Port-level checks on the sampler sequencer mixer unit.
// ---------------------------------------------------------------------------
`include "sampler_sequencer_mixer_unit_assert.svh"
module ssm_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_ready,
  input logic [7:0] audio_out
);
  `SSM_ASSERT_IMPL(a_no_in_while_out, clk, rst, out_valid, !in_ready, "request taken while result waits")
  `SSM_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `SSM_ASSERT_NEXT(a_audio_holds, clk, rst, out_valid && !out_ready, $stable(audio_out), "audio changed while waiting")
  `SSM_ASSERT_NEXT(a_one_result, clk, rst, in_valid && in_ready, !out_valid, "result too early")
  `SSM_ASSERT_IMPL(a_cfg_idle, clk, rst, cfg_ready, in_ready, "config while busy")
endmodule

bind sampler_sequencer_mixer_unit ssm_checker u_ssm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cfg_ready(cfg_ready),
  .audio_out(audio_out)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: sampler sequencer mixer unit
// Drives requests, register writes and output stalls into the drum sampler.
// A behavioural copy of the sampler (store, grid, voices, debounce) predicts
// results no typed table row fixes. A short directed table comes first, then
// random phases under varied sample lengths and debounce settings.
// ----------------------------------------------------------------------------
module tb;
  import ssm_pkg::*;

  localparam int CycleLimit = 3_000_000;

  typedef struct packed {
    logic [7:0] audio;
    logic [3:0] step;
    logic [3:0] col;
    logic [7:0] busy;
    logic       acc;
  } result_t;

  typedef struct {
    bit          is_cfg;
    cfg_idx_t    idx;
    logic [19:0] data;
    req_t        r;
    logic [1:0]  s;
    logic [11:0] a;
    logic [7:0]  d;
    logic [47:0] t;
    bit          typed;
    result_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [1:0]  sample_id = '0;
  logic [11:0] byte_addr = '0;
  logic [7:0]  byte_value = '0;
  logic [47:0] time_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  audio_out;
  logic [3:0]  seq_step;
  logic [3:0]  step_column;
  logic [7:0]  voices_busy;
  logic        accepted;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // behavioural copy of the sampler
  logic [7:0]  snd_mem [4][4096];
  bit          snd_written [4][4096];
  logic [15:0] grid [4];
  logic [3:0]  step_q;
  bit          vact [8];
  logic [1:0]  vsnd [8];
  logic [12:0] vpos [8];
  logic [47:0] last_t [4];
  bit          pressed [4];
  logic [12:0] len_q [4];
  logic [19:0] deb_q;

  result_t pending_results[$];
  row_t    rows[$];
  int      fails = 0;
  int      n_requests = 0;
  int      n_checked = 0;
  int      n_settings = 0;
  int      cycles = 0;
  bit      no_gaps = 1'b0;

  sampler_sequencer_mixer_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .sample_id(sample_id), .byte_addr(byte_addr),
    .byte_value(byte_value), .time_us(time_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .audio_out(audio_out), .seq_step(seq_step), .step_column(step_column),
    .voices_busy(voices_busy), .accepted(accepted),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && (no_gaps || $urandom_range(99) >= 34);
  end

  function automatic logic [12:0] sound_len(logic [1:0] s);
    return (len_q[s] > 13'd4096) ? 13'd4096 : len_q[s];
  endfunction

  function automatic bit voice_live(int v);
    return vact[v] && (vpos[v] < sound_len(vsnd[v]));
  endfunction

  function automatic bit claim_voice(logic [1:0] s);
    if (sound_len(s) == 0) return 1'b0;
    for (int v = 0; v < 8; v++) begin
      if (!voice_live(v)) begin
        vact[v] = 1'b1;
        vsnd[v] = s;
        vpos[v] = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] mix_voices();
    int acc;
    logic [12:0] l;
    acc = 128;
    for (int v = 0; v < 8; v++) begin
      if (!vact[v]) continue;
      l = sound_len(vsnd[v]);
      if (vpos[v] >= l) begin
        vact[v] = 1'b0;
        continue;
      end
      acc = acc + int'(snd_mem[vsnd[v]][vpos[v][11:0]]) - 128;
      if (acc > 255) acc = 255;
      if (acc < 0) acc = 0;
      vpos[v] = vpos[v] + 13'd1;
      if (vpos[v] >= l) vact[v] = 1'b0;
    end
    return acc[7:0];
  endfunction

  function automatic result_t predict_request(req_t r, logic [1:0] s, logic [11:0] a,
                                              logic [7:0] d, logic [47:0] t);
    result_t res;
    logic [47:0] diff;
    res = '0;
    res.audio = MidLevel;
    case (r)
      REQ_LOAD: begin
        snd_mem[s][a] = d;
        snd_written[s][a] = 1'b1;
      end
      REQ_STEP: begin
        step_q = step_q + 4'd1;
        for (int i = 0; i < 4; i++)
          if (grid[i][step_q] && claim_voice(i[1:0])) res.acc = 1'b1;
      end
      REQ_PRESS: begin
        diff = t - last_t[s];
        if (!pressed[s] || diff > {28'd0, deb_q}) begin
          last_t[s] = t;
          pressed[s] = 1'b1;
          void'(claim_voice(s));
          grid[s][step_q] = !grid[s][step_q];
          res.acc = 1'b1;
        end
      end
      default: res.audio = mix_voices();
    endcase
    res.step = step_q;
    for (int i = 0; i < 4; i++) res.col[i] = grid[i][step_q];
    for (int v = 0; v < 8; v++) res.busy[v] = voice_live(v);
    return res;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_results.pop_front();
        if (audio_out !== w.audio) flag_mismatch("audio_out", audio_out, w.audio);
        if (seq_step !== w.step) flag_mismatch("seq_step", seq_step, w.step);
        if (step_column !== w.col) flag_mismatch("step_column", step_column, w.col);
        if (voices_busy !== w.busy) flag_mismatch("voices_busy", voices_busy, w.busy);
        if (accepted !== w.acc) flag_mismatch("accepted", accepted, w.acc);
        n_checked++;
      end
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(req_t r, logic [1:0] s, logic [11:0] a, logic [7:0] d,
                              logic [47:0] t, bit typed, result_t want);
    result_t got;
    if (!no_gaps && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= r;
    sample_id <= s;
    byte_addr <= a;
    byte_value <= d;
    time_us <= t;
    do @(posedge clk); while (!in_ready);
    got = predict_request(r, s, a, d, t);
    pending_results.push_back(typed ? want : got);
    n_requests++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(cfg_idx_t idx, logic [19:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DEB) deb_q = d;
    else len_q[idx[1:0]] = d[12:0];
  endtask

  // fills any byte that a playing voice is about to read before mixing
  task automatic audio_request();
    result_t z;
    z = '0;
    for (int v = 0; v < 8; v++)
      if (voice_live(v) && !snd_written[vsnd[v]][vpos[v][11:0]])
        send_request(REQ_LOAD, vsnd[v], vpos[v][11:0], 8'($urandom), rand48(), 1'b0, z);
    send_request(REQ_AUDIO, 2'($urandom), 12'($urandom), 8'($urandom), rand48(), 1'b0, z);
  endtask

  function automatic result_t res(int au, int st, int c, int b, int ac);
    result_t x;
    x.audio = 8'(au);
    x.step = 4'(st);
    x.col = 4'(c);
    x.busy = 8'(b);
    x.acc = 1'(ac);
    return x;
  endfunction

  task automatic add_req(req_t r, logic [1:0] s, logic [11:0] a, logic [7:0] d,
                         logic [47:0] t, bit typed, result_t want);
    row_t x;
    x.is_cfg = 1'b0;
    x.idx = CFG_LEN0;
    x.data = '0;
    x.r = r;
    x.s = s;
    x.a = a;
    x.d = d;
    x.t = t;
    x.typed = typed;
    x.want = want;
    rows.push_back(x);
  endtask

  task automatic add_cfg(cfg_idx_t idx, logic [19:0] d);
    row_t x;
    x.is_cfg = 1'b1;
    x.idx = idx;
    x.data = d;
    x.r = REQ_LOAD;
    x.s = '0;
    x.a = '0;
    x.d = '0;
    x.t = '0;
    x.typed = 1'b0;
    x.want = '0;
    rows.push_back(x);
  endtask

  function automatic logic [19:0] pick_len(int ph);
    int r;
    r = $urandom_range(19);
    if (ph == 2) return 20'd8191;
    if (ph == 7) return 20'd4096;
    if (r == 0) return 20'd0;
    if (r == 1) return 20'd4096;
    return 20'($urandom_range(1, 48));
  endfunction

  function automatic logic [19:0] pick_deb(int ph);
    if (ph == 0) return 20'd0;
    if (ph == 4) return 20'hFFFFF;
    return 20'($urandom_range(0, 200000));
  endfunction

  initial begin
    result_t z;
    logic [47:0] t_now;
    bit in_cfg;
    int sel;
    z = '0;
    t_now = '0;
    in_cfg = 1'b0;
    for (int i = 0; i < 4; i++) begin
      grid[i] = '0;
      last_t[i] = '0;
      pressed[i] = 1'b0;
      len_q[i] = '0;
      for (int j = 0; j < 4096; j++) snd_written[i][j] = 1'b0;
    end
    for (int v = 0; v < 8; v++) begin
      vact[v] = 1'b0;
      vsnd[v] = '0;
      vpos[v] = '0;
    end
    step_q = '0;
    deb_q = DebounceReset;

    add_req(REQ_AUDIO, 0, 0, 0, 0, 1, res(128, 0, 0, 0, 0));
    add_req(REQ_STEP, 0, 0, 0, 0, 1, res(128, 1, 0, 0, 0));
    add_req(REQ_PRESS, 0, 0, 0, 0, 1, res(128, 1, 1, 0, 1));
    add_req(REQ_PRESS, 0, 0, 0, 48'd70000, 1, res(128, 1, 1, 0, 0));
    add_req(REQ_PRESS, 0, 0, 0, 48'd70001, 1, res(128, 1, 0, 0, 1));
    add_req(REQ_PRESS, 3, 0, 0, 48'hFFFF_FFFF_FFFF, 1, res(128, 1, 8, 0, 1));
    add_req(REQ_PRESS, 3, 0, 0, 48'd0, 1, res(128, 1, 8, 0, 0));
    add_req(REQ_LOAD, 3, 12'd4095, 8'd255, 0, 1, res(128, 1, 8, 0, 0));
    add_req(REQ_LOAD, 0, 0, 8'd255, 0, 1, res(128, 1, 8, 0, 0));
    add_req(REQ_LOAD, 1, 0, 8'd255, 0, 1, res(128, 1, 8, 0, 0));
    add_req(REQ_LOAD, 2, 0, 8'd0, 0, 1, res(128, 1, 8, 0, 0));
    add_req(REQ_LOAD, 3, 0, 8'd0, 0, 1, res(128, 1, 8, 0, 0));
    add_cfg(CFG_LEN0, 20'd1);
    add_cfg(CFG_LEN1, 20'd2);
    add_cfg(CFG_LEN2, 20'd8191);
    add_cfg(CFG_LEN3, 20'd4096);
    add_cfg(CFG_DEB, 20'd0);
    add_req(REQ_LOAD, 1, 1, 8'd255, 0, 0, z);
    add_req(REQ_LOAD, 2, 1, 8'd0, 0, 0, z);
    add_req(REQ_LOAD, 3, 1, 8'd0, 0, 0, z);
    add_req(REQ_PRESS, 0, 0, 0, 48'd1, 0, z);
    add_req(REQ_PRESS, 1, 0, 0, 48'd2, 0, z);
    add_req(REQ_PRESS, 2, 0, 0, 48'd3, 0, z);
    add_req(REQ_PRESS, 3, 0, 0, 48'd4, 0, z);
    add_req(REQ_AUDIO, 0, 0, 0, 0, 0, z);
    add_req(REQ_AUDIO, 0, 0, 0, 0, 0, z);
    add_req(REQ_STEP, 0, 0, 0, 0, 0, z);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    n_settings = 2;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        cfg_write(rows[i].idx, rows[i].data);
      end else begin
        if (in_cfg) cfg_valid <= 1'b0;
        in_cfg = 1'b0;
        send_request(rows[i].r, rows[i].s, rows[i].a, rows[i].d, rows[i].t,
                     rows[i].typed, rows[i].want);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      no_gaps = (ph == 3);
      for (int k = 0; k < 4; k++) cfg_write(cfg_idx_t'(k), pick_len(ph));
      cfg_write(CFG_DEB, pick_deb(ph));
      cfg_valid <= 1'b0;
      n_settings++;
      while (n_requests < 22 + (ph + 1) * 228) begin
        sel = $urandom_range(99);
        if (sel < 12) begin
          send_request(REQ_LOAD, 2'($urandom), 12'($urandom), 8'($urandom), rand48(), 0, z);
        end else if (sel < 30) begin
          send_request(REQ_STEP, 2'($urandom), 12'($urandom), 8'($urandom), rand48(), 0, z);
        end else if (sel < 50) begin
          sel = $urandom_range(9);
          if (sel < 3) t_now = t_now + 48'($urandom_range(0, deb_q));
          else if (sel < 8) t_now = t_now + 48'(deb_q) + 48'($urandom_range(1, 5000));
          else if (sel == 8) t_now = rand48();
          send_request(REQ_PRESS, 2'($urandom), 12'($urandom), 8'($urandom), t_now, 0, z);
        end else begin
          audio_request();
        end
      end
    end

    drain();
    no_gaps = 1'b0;
    $display("tb: %0d requests sent, %0d results checked under %0d register settings",
             n_requests, n_checked, n_settings);
    $display("tb: %0d mismatches", fails);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
